// File: design/clce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clce_pkg
// Shared constants for the circular list cursor engine: pool sizing,
// field widths, command and status codes.
// ----------------------------------------------------------------------------
package clce_pkg;

    localparam int POOL_DEPTH = 1024;
    localparam int ADDR_W     = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CNT_W      = $clog2(POOL_DEPTH + 1);

    localparam int CMD_W      = 3;
    localparam int OFFSET_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = OFFSET_W + VALUE_W;

    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PHASE = 2'd3;

endpackage

// File: design/circular_list_cursor_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_list_cursor_engine_unit
// Circular singly linked list in a node pool, walked by a link sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   One command item enters on the s_axis channel (cmd in tuser, offset and
//   value in tdata); exactly one result item leaves on m_axis (status in
//   tuser, read word in tdata). One item is handled at a time: s_axis_tready
//   is high only while the engine is idle.
//   Append, close and unused codes go straight to the result state; an
//   append onto a non-empty list first passes S_WR2 for a second link
//   write. Insert, remove and read walk the link memory one node per
//   cycle for a step count taken from offset; then insert passes S_WR2
//   and remove S_REM before the result. The walk rate is set by the
//   single registered read port of the link memory. Every error case
//   goes straight to the result without touching the list. Once the
//   result is taken the engine returns to idle and takes the next item.
//   Reset clears pointers, counters and the ring flag; the node memories
//   are not cleared and need no sweep, so items are taken straight away.
//   If m_axis_tready stays low the result is held in its register and no
//   new item is taken until it has gone.
// ----------------------------------------------------------------------------
module circular_list_cursor_engine_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [clce_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // offset, value
    input  logic [clce_pkg::CMD_W-1:0]            s_axis_tuser,  // cmd
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic signed [clce_pkg::VALUE_W-1:0]   m_axis_tdata,  // read_value
    output logic [clce_pkg::STATUS_W-1:0]         m_axis_tuser   // status
);
    import clce_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WALK = 3'd1;
    localparam logic [2:0] S_REM  = 3'd2;
    localparam logic [2:0] S_WR2  = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          free_top_reg, free_top_next;
    logic [CNT_W-1:0]          fresh_used_reg, fresh_used_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [ADDR_W-1:0]         head_reg, head_next;
    logic [ADDR_W-1:0]         cursor_reg, cursor_next;
    logic                      closed_reg, closed_next;

    logic [OFFSET_W-1:0]       step_reg, step_next;
    logic [CMD_W-1:0]          cmd_reg, cmd_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [ADDR_W-1:0]         victim_reg, victim_next;
    logic [ADDR_W-1:0]         wr2_addr_reg, wr2_addr_next;
    logic [ADDR_W-1:0]         wr2_data_reg, wr2_data_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VALUE_W-1:0] rd_reg, rd_next;

    logic signed [VALUE_W-1:0] node_value_reg [POOL_DEPTH];
    logic [ADDR_W-1:0]         node_link_reg  [POOL_DEPTH];
    logic [ADDR_W-1:0]         free_stack_reg [POOL_DEPTH];
    logic signed [VALUE_W-1:0] value_rd_reg;
    logic [ADDR_W-1:0]         link_rd_reg;
    logic [ADDR_W-1:0]         free_rd_reg;

    logic [CMD_W-1:0]          in_cmd;
    logic [OFFSET_W-1:0]       in_offset;
    logic signed [VALUE_W-1:0] in_value;
    logic                      room;
    logic [CNT_W-1:0]          free_top_m1;
    logic [ADDR_W-1:0]         take_node;
    logic [ADDR_W-1:0]         fs_raddr;
    logic [ADDR_W-1:0]         raddr;

    logic                      lw_en;
    logic [ADDR_W-1:0]         lw_addr;
    logic [ADDR_W-1:0]         lw_data;
    logic                      vw_en;
    logic [ADDR_W-1:0]         vw_addr;
    logic signed [VALUE_W-1:0] vw_data;
    logic                      fw_en;
    logic [ADDR_W-1:0]         fw_addr;
    logic [ADDR_W-1:0]         fw_data;

    assign in_cmd      = s_axis_tuser;
    assign in_offset   = s_axis_tdata[OFFSET_W-1:0];
    assign in_value    = s_axis_tdata[IN_DATA_W-1:OFFSET_W];
    assign room        = (free_top_reg != '0) || (fresh_used_reg < CNT_W'(POOL_DEPTH));
    assign free_top_m1 = free_top_reg - CNT_W'(1);
    assign fs_raddr    = free_top_m1[ADDR_W-1:0];
    assign take_node   = (free_top_reg != '0) ? free_rd_reg : fresh_used_reg[ADDR_W-1:0];
    // walking: address the node the link register points at
    assign raddr       = (state_reg == S_WALK) ? link_rd_reg : cursor_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_RESP);
    assign m_axis_tdata  = rd_reg;
    assign m_axis_tuser  = status_reg;

    always_comb
    begin
        state_next      = state_reg;
        free_top_next   = free_top_reg;
        fresh_used_next = fresh_used_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        cursor_next     = cursor_reg;
        closed_next     = closed_reg;
        step_next       = step_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        victim_next     = victim_reg;
        wr2_addr_next   = wr2_addr_reg;
        wr2_data_next   = wr2_data_reg;
        status_next     = status_reg;
        rd_next         = rd_reg;
        lw_en           = 1'b0;
        lw_addr         = cursor_reg;
        lw_data         = take_node;
        vw_en           = 1'b0;
        vw_addr         = take_node;
        vw_data         = value_reg;
        fw_en           = 1'b0;
        fw_addr         = free_top_reg[ADDR_W-1:0];
        fw_data         = victim_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next    = in_cmd;
                    value_next  = in_value;
                    status_next = ST_OK;
                    rd_next     = '0;
                    state_next  = S_RESP;
                    case (in_cmd)
                        CMD_APPEND:
                        begin
                            if (closed_reg)
                                status_next = ST_PHASE;
                            else if (!room)
                                status_next = ST_FULL;
                            else
                            begin
                                vw_en   = 1'b1;
                                vw_addr = take_node;
                                vw_data = in_value;
                                lw_en   = 1'b1;
                                if (count_reg == '0)
                                begin
                                    head_next = take_node;
                                    lw_addr   = take_node;
                                    lw_data   = take_node;
                                end
                                else
                                begin
                                    lw_addr       = cursor_reg;
                                    lw_data       = take_node;
                                    wr2_addr_next = take_node;
                                    wr2_data_next = take_node;
                                    state_next    = S_WR2;
                                end
                                cursor_next = take_node;
                                count_next  = count_reg + CNT_W'(1);
                                if (free_top_reg != '0)
                                    free_top_next = free_top_m1;
                                else
                                    fresh_used_next = fresh_used_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLOSE:
                        begin
                            if (closed_reg)
                                status_next = ST_PHASE;
                            else if (count_reg == '0)
                                status_next = ST_FEW;
                            else
                            begin
                                lw_en       = 1'b1;
                                lw_addr     = cursor_reg;
                                lw_data     = head_reg;
                                cursor_next = head_reg;
                                closed_next = 1'b1;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (!closed_reg)
                                status_next = ST_PHASE;
                            else if (!room)
                                status_next = ST_FULL;
                            else
                            begin
                                step_next  = (in_offset > OFFSET_W'(1)) ?
                                             in_offset - OFFSET_W'(1) : '0;
                                state_next = S_WALK;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (!closed_reg)
                                status_next = ST_PHASE;
                            else if (count_reg < CNT_W'(2))
                                status_next = ST_FEW;
                            else
                            begin
                                step_next  = (in_offset > OFFSET_W'(2)) ?
                                             in_offset - OFFSET_W'(2) : '0;
                                state_next = S_WALK;
                            end
                        end
                        CMD_READ:
                        begin
                            if (!closed_reg)
                                status_next = ST_PHASE;
                            else
                            begin
                                step_next  = (in_offset > OFFSET_W'(1)) ?
                                             in_offset - OFFSET_W'(1) : '0;
                                state_next = S_WALK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                if (step_reg != '0)
                begin
                    cursor_next = link_rd_reg;
                    step_next   = step_reg - OFFSET_W'(1);
                end
                else
                begin
                    case (cmd_reg)
                        CMD_READ:
                        begin
                            rd_next    = value_rd_reg;
                            state_next = S_RESP;
                        end
                        CMD_INSERT:
                        begin
                            vw_en         = 1'b1;
                            vw_addr       = take_node;
                            vw_data       = value_reg;
                            lw_en         = 1'b1;
                            lw_addr       = cursor_reg;
                            lw_data       = take_node;
                            wr2_addr_next = take_node;
                            wr2_data_next = link_rd_reg;
                            cursor_next   = take_node;
                            count_next    = count_reg + CNT_W'(1);
                            if (free_top_reg != '0)
                                free_top_next = free_top_m1;
                            else
                                fresh_used_next = fresh_used_reg + CNT_W'(1);
                            state_next    = S_WR2;
                        end
                        CMD_REMOVE:
                        begin
                            victim_next = link_rd_reg;
                            state_next  = S_REM;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_REM:
            begin
                // link register now holds the successor of the victim
                lw_en       = 1'b1;
                lw_addr     = cursor_reg;
                lw_data     = link_rd_reg;
                cursor_next = link_rd_reg;
                if (victim_reg == head_reg)
                    head_next = link_rd_reg;
                if (free_top_reg < CNT_W'(POOL_DEPTH))
                begin
                    fw_en         = 1'b1;
                    fw_addr       = free_top_reg[ADDR_W-1:0];
                    fw_data       = victim_reg;
                    free_top_next = free_top_reg + CNT_W'(1);
                end
                count_next = count_reg - CNT_W'(1);
                state_next = S_RESP;
            end
            S_WR2:
            begin
                lw_en      = 1'b1;
                lw_addr    = wr2_addr_reg;
                lw_data    = wr2_data_reg;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (m_axis_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            free_top_reg   <= '0;
            fresh_used_reg <= '0;
            count_reg      <= '0;
            head_reg       <= '0;
            cursor_reg     <= '0;
            closed_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_top_reg   <= free_top_next;
            fresh_used_reg <= fresh_used_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            cursor_reg     <= cursor_next;
            closed_reg     <= closed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        cmd_reg      <= cmd_next;
        value_reg    <= value_next;
        victim_reg   <= victim_next;
        wr2_addr_reg <= wr2_addr_next;
        wr2_data_reg <= wr2_data_next;
        status_reg   <= status_next;
        rd_reg       <= rd_next;
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
            node_link_reg[lw_addr] <= lw_data;
        link_rd_reg <= node_link_reg[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (vw_en)
            node_value_reg[vw_addr] <= vw_data;
        value_rd_reg <= node_value_reg[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fw_en)
            free_stack_reg[fw_addr] <= fw_data;
        free_rd_reg <= free_stack_reg[fs_raddr];
    end

endmodule

// File: design/clce_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clce_checker
// Port-level checks on the circular list cursor engine, bound to the top.
// ----------------------------------------------------------------------------
module clce_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic [clce_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // offset, value
    input logic [clce_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [clce_pkg::VALUE_W-1:0]        m_axis_tdata,  // read_value
    input logic [clce_pkg::STATUS_W-1:0]       m_axis_tuser   // status
);
    import clce_pkg::*;

    // one item in flight: never ready while a result waits
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("ready stayed high after an accepted item");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed or dropped");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("result repeated");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == '0))
        else $error("nonzero read word with failing status");

endmodule

bind circular_list_cursor_engine_unit clce_checker u_clce_checker (.*);
